// ===== rtl/core/ps2mc_pkg.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse cursor package
// Shared widths, register indexes, packet and CSR types, clamp helpers.
// ----------------------------------------------------------------------------
package ps2mc_pkg;

   localparam int COORD_BITS = 12;              // cursor position state width
   localparam int CURSOR_W   = 12;              // result field width
   localparam int BYTE_W     = 8;
   localparam int CFG_W      = 13;              // screen size register width
   localparam int CSR_IDX_W  = 4;
   localparam int SUM_W      = COORD_BITS + 2;  // position plus signed delta
   localparam int LIM_W      = ((COORD_BITS > CFG_W) ? COORD_BITS : CFG_W) + 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_HEIGHT = CSR_IDX_W'(1);

   localparam logic [CFG_W-1:0] RESET_WIDTH  = CFG_W'(320);
   localparam logic [CFG_W-1:0] RESET_HEIGHT = CFG_W'(200);
   localparam logic [COORD_BITS-1:0] RESET_POS_X = COORD_BITS'(160);
   localparam logic [COORD_BITS-1:0] RESET_POS_Y = COORD_BITS'(100);
   localparam logic [COORD_BITS-1:0] COORD_MAX   = '1;

   localparam int HDR_SYNC_BIT = 3;   // always set in a valid header byte
   localparam int HDR_LEFT_BIT = 0;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_DELTA_X = 2'd1,
      PH_DELTA_Y = 2'd2
   } phase_type;

   typedef struct packed {
      logic              left;
      logic [BYTE_W-1:0] dx;
      logic [BYTE_W-1:0] dy;
   } pkt_type;

   typedef struct packed {
      logic                 valid;
      logic [CSR_IDX_W-1:0] index;
      logic [CFG_W-1:0]     data;
   } csr_wr_type;

   // Highest coordinate for a screen size; zero acts as one, saturates at
   // the top of the coordinate range.
   function automatic logic [COORD_BITS-1:0] limit_of(input logic [CFG_W-1:0] size);
      logic [CFG_W-1:0] lim;
      logic [LIM_W-1:0] lim_w;
      lim   = (size == '0) ? '0 : size - CFG_W'(1);
      lim_w = LIM_W'(lim);
      if (lim_w > LIM_W'(COORD_MAX)) begin
         return COORD_MAX;
      end
      return COORD_BITS'(lim_w);
   endfunction

   function automatic logic [COORD_BITS-1:0] clamp_coord(
      input logic signed [SUM_W-1:0] v,
      input logic [COORD_BITS-1:0]   hi
   );
      logic [SUM_W-2:0] mag;
      mag = v[SUM_W-2:0];
      if (v[SUM_W-1]) begin
         return '0;
      end
      if (mag > {1'b0, hi}) begin
         return hi;
      end
      return COORD_BITS'(mag);
   endfunction

endpackage

// ===== rtl/core/ps2mc_front.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse packet assembler
// Filters mouse-channel bytes and collects three-byte packets.
// ----------------------------------------------------------------------------
module ps2mc_front
   import ps2mc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_xfer,
   input  logic [BYTE_W-1:0] rx_byte,
   input  logic              from_aux,
   output logic              push,
   output pkt_type           push_pkt
);

   phase_type         phase_ff, phase_in;
   logic [BYTE_W-1:0] header_ff, header_in;
   logic [BYTE_W-1:0] dx_ff, dx_in;
   logic              aux_xfer;

   assign aux_xfer = in_xfer && from_aux;

   // next state
   always_comb begin
      phase_in = phase_ff;
      if (aux_xfer) begin
         unique case (phase_ff)
            PH_DELTA_X: phase_in = PH_DELTA_Y;
            PH_DELTA_Y: phase_in = PH_HEADER;
            default:    phase_in = rx_byte[HDR_SYNC_BIT] ? PH_DELTA_X : PH_HEADER;
         endcase
      end
   end

   // outputs and byte capture
   always_comb begin
      push      = 1'b0;
      header_in = header_ff;
      dx_in     = dx_ff;
      if (aux_xfer) begin
         unique case (phase_ff)
            PH_DELTA_X: dx_in = rx_byte;
            PH_DELTA_Y: push  = 1'b1;
            default: begin
               if (rx_byte[HDR_SYNC_BIT]) header_in = rx_byte;
            end
         endcase
      end
      push_pkt.left = header_ff[HDR_LEFT_BIT];
      push_pkt.dx   = dx_ff;
      push_pkt.dy   = rx_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
      end else begin
         phase_ff <= phase_in;
      end
      header_ff <= header_in;
      dx_ff     <= dx_in;
   end

endmodule

// ===== rtl/core/ps2mc_fifo.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse packet queue
// Short queue between packet assembly and cursor update.
// ----------------------------------------------------------------------------
module ps2mc_fifo
   import ps2mc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  pkt_type push_pkt,
   input  logic    pop,
   output logic    full,
   output logic    not_empty,
   output pkt_type head_pkt
);

   pkt_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head_pkt  = entry_ff[rd_ptr_ff];

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + QCNT_W'(1);
      if (do_pop && !do_push) count_in = count_ff - QCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) entry_ff[wr_ptr_ff] <= push_pkt;
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("packet queue count out of range");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("packet pushed into full queue");
`endif

endmodule

// ===== rtl/core/ps2mc_back.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse cursor update
// Applies packet deltas, clamps to the screen, holds the result register.
// ----------------------------------------------------------------------------
module ps2mc_back
   import ps2mc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  csr_wr_type          csr_wr,
   input  logic                q_not_empty,
   input  pkt_type             q_pkt,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [CURSOR_W-1:0] rsp_cursor_x,
   output logic [CURSOR_W-1:0] rsp_cursor_y,
   output logic                rsp_button_left
);

   logic [COORD_BITS-1:0]   limit_x_ff, limit_x_in;
   logic [COORD_BITS-1:0]   limit_y_ff, limit_y_in;
   logic [COORD_BITS-1:0]   pos_x_ff, pos_x_in;
   logic [COORD_BITS-1:0]   pos_y_ff, pos_y_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CURSOR_W-1:0]     cur_x_ff, cur_y_ff;
   logic                    left_ff;
   logic signed [SUM_W-1:0] sum_x, sum_y;

   // limits are kept pre-computed from the size registers
   always_comb begin
      limit_x_in = limit_x_ff;
      limit_y_in = limit_y_ff;
      if (csr_wr.valid) begin
         if (csr_wr.index == REG_SCREEN_WIDTH)  limit_x_in = limit_of(csr_wr.data);
         if (csr_wr.index == REG_SCREEN_HEIGHT) limit_y_in = limit_of(csr_wr.data);
      end
   end

   assign pop = q_not_empty && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      sum_x = $signed({2'b00, pos_x_ff}) + SUM_W'($signed(q_pkt.dx));
      sum_y = $signed({2'b00, pos_y_ff}) - SUM_W'($signed(q_pkt.dy));
      pos_x_in = pop ? clamp_coord(sum_x, limit_x_ff) : pos_x_ff;
      pos_y_in = pop ? clamp_coord(sum_y, limit_y_ff) : pos_y_ff;
      rsp_valid_in = pop || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_x_ff   <= limit_of(RESET_WIDTH);
         limit_y_ff   <= limit_of(RESET_HEIGHT);
         pos_x_ff     <= RESET_POS_X;
         pos_y_ff     <= RESET_POS_Y;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_x_ff   <= limit_x_in;
         limit_y_ff   <= limit_y_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (pop) begin
         cur_x_ff <= CURSOR_W'(pos_x_in);
         cur_y_ff <= CURSOR_W'(pos_y_in);
         left_ff  <= q_pkt.left;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cursor_x    = cur_x_ff;
   assign rsp_cursor_y    = cur_y_ff;
   assign rsp_button_left = left_ff;

`ifndef SYNTH
   a_pop_shows: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid_ff && (cur_x_ff == CURSOR_W'(pos_x_ff))
              && (cur_y_ff == CURSOR_W'(pos_y_ff)))
      else $error("result register does not match updated position");

   a_clamped: assert property (@(posedge clock) disable iff (reset)
      pop |=> (pos_x_ff <= $past(limit_x_ff)) && (pos_y_ff <= $past(limit_y_ff)))
      else $error("cursor outside screen after update");
`endif

endmodule

// ===== rtl/core/ps2_mouse_packet_cursor_core.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse packet cursor core
// Decodes three-byte mouse packets into a clamped cursor position.
// ----------------------------------------------------------------------------
// Accepts one controller byte per clock while req_stall is low. Bytes with
// req_from_aux low are discarded; a header byte without bit 3 set is dropped
// to resync. Each completed packet yields one result with the clamped cursor
// and left button: the assembler writes the packet into a two-entry queue
// when the third byte is taken, and the cursor update loads the result
// register when it pops the packet. req_stall rises only when that queue is
// full, which happens only while rsp_stall holds back results.
// Screen size registers (index 0 width, 1 height) are written through csr_*,
// which is always ready.
module ps2_mouse_packet_cursor_core
   import ps2mc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [BYTE_W-1:0]    req_rx_byte,
   input  logic                 req_from_aux,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [CURSOR_W-1:0]  rsp_cursor_x,
   output logic [CURSOR_W-1:0]  rsp_cursor_y,
   output logic                 rsp_button_left,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   logic       in_xfer;
   logic       push, pop, q_full, q_not_empty;
   pkt_type    push_pkt, head_pkt;
   csr_wr_type csr_wr;

   assign csr_ready    = 1'b1;
   assign csr_wr.valid = csr_valid && csr_ready;
   assign csr_wr.index = csr_index;
   assign csr_wr.data  = csr_wdata;

   assign req_stall = q_full;
   assign in_xfer   = req_valid && !req_stall;

   ps2mc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_xfer  (in_xfer),
      .rx_byte  (req_rx_byte),
      .from_aux (req_from_aux),
      .push     (push),
      .push_pkt (push_pkt)
   );

   ps2mc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_pkt  (push_pkt),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_pkt  (head_pkt)
   );

   ps2mc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .csr_wr          (csr_wr),
      .q_not_empty     (q_not_empty),
      .q_pkt           (head_pkt),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_cursor_x    (rsp_cursor_x),
      .rsp_cursor_y    (rsp_cursor_y),
      .rsp_button_left (rsp_button_left)
   );

endmodule
